>>> rtl/tsp_pkg.sv
// Shared types and constants for the timestamp text parser.
// No dependencies; every other file in rtl/ imports this package.
package tsp_pkg;

  localparam int unsigned SecWidth  = 32;
  localparam int unsigned MsWidth   = 10;
  localparam int unsigned CharWidth = 8;

  localparam logic [CharWidth-1:0] CHAR_COLON = 8'h3A;
  localparam logic [CharWidth-1:0] CHAR_DOT   = 8'h2E;
  localparam logic [CharWidth-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CharWidth-1:0] CHAR_NINE  = 8'h39;

  localparam logic [SecWidth-1:0] SEC_SAT = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    MODE_LEAD  = 2'd0,   // leading block, free length
    MODE_FIXED = 2'd1,   // two-digit block after a colon
    MODE_FRAC  = 2'd2    // fraction after the dot
  } mode_t;

  typedef struct packed {
    logic [CharWidth-1:0] char_code;
    logic                 final_char;
  } char_word_t;

  typedef struct packed {
    logic [SecWidth-1:0] total_seconds;
    logic [MsWidth-1:0]  millis;
    logic                parse_ok;
  } time_word_t;

  typedef struct packed {
    mode_t               mode;
    logic [1:0]          digit_count;
    logic [SecWidth-1:0] seconds_sum;
    logic [SecWidth-1:0] block_value;
    logic [MsWidth-1:0]  fraction_value;
    logic                error_seen;
  } parse_state_t;

  localparam parse_state_t STATE_CLEAR = '{
    mode:           MODE_LEAD,
    digit_count:    2'd0,
    seconds_sum:    '0,
    block_value:    '0,
    fraction_value: '0,
    error_seen:     1'b0
  };

endpackage

>>> rtl/timestamp_text_parser_top.sv
// Top level of the timestamp text parser: input register, parse state, result register.
// Depends on tsp_pkg, tsp_step and tsp_emit.
//
// Usage:
//   char_valid/char_stall/char_data carry one ASCII character per word, with
//   final_char set on the last character of a timestamp "[h:]mm:ss.fff".
//   time_valid/time_stall/time_data carry one result word per timestamp:
//   total seconds, milliseconds and a parse_ok flag. Characters without
//   final_char produce no result word.
//   Throughput: one character per cycle, sustained, while time_stall is low.
//   The final character passes from the input register into the result
//   register, where time_valid is raised together with its result word.
//   The character path between the two registers is the per-character update
//   plus the final fold, all constant multiplies, adds and compares.
//   Reset (rst, synchronous, active high) empties both registers and returns
//   the parser to the start of a timestamp.
//   When the receiver holds time_stall, the result word holds; a character
//   already in the input register waits, and char_stall rises only once the
//   input register is also occupied, so no word is lost or repeated.
module timestamp_text_parser_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                char_valid,
  output logic                char_stall,
  input  tsp_pkg::char_word_t char_data,
  output logic                time_valid,
  input  logic                time_stall,
  output tsp_pkg::time_word_t time_data
);
  import tsp_pkg::*;

  logic         hold_valid;
  char_word_t   hold_word;
  parse_state_t state;
  parse_state_t state_next;
  time_word_t   result_next;
  logic         out_free;
  logic         advance;

  // result register can take a new word
  assign out_free   = !time_valid || !time_stall;
  // the character in the input register is processed this cycle
  assign advance    = hold_valid && out_free;
  assign char_stall = hold_valid && !out_free;

  tsp_step u_step (
    .cur       (state),
    .char_code (hold_word.char_code),
    .nxt       (state_next)
  );

  tsp_emit u_emit (
    .st     (state_next),
    .result (result_next)
  );

  // input register: refill whenever it is empty or being drained
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!char_stall) begin
      hold_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!char_stall && char_valid) begin
      hold_word <= char_data;
    end
  end

  // parse state: advance per character, clear after the final one
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_CLEAR;
    end else if (advance) begin
      state <= hold_word.final_char ? STATE_CLEAR : state_next;
    end
  end

  // result register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      time_valid <= 1'b0;
    end else if (out_free) begin
      time_valid <= advance && hold_word.final_char;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hold_word.final_char) begin
      time_data <= result_next;
    end
  end

endmodule

>>> rtl/tsp_step.sv
// Per-character update of the parser state.
// Depends on tsp_pkg.
module tsp_step (
  input  tsp_pkg::parse_state_t        cur,
  input  logic [tsp_pkg::CharWidth-1:0] char_code,
  output tsp_pkg::parse_state_t        nxt
);
  import tsp_pkg::*;

  logic                is_digit;
  logic [3:0]          digit;
  logic [35:0]         lead_value;
  logic [32:0]         fold_sum;
  logic [38:0]         fold_min;
  logic [SecWidth-1:0] fixed_value;
  logic [MsWidth-1:0]  frac_next;
  logic                is_colon;
  logic                is_dot;

  assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
  assign digit    = is_digit ? char_code[3:0] : 4'd0;
  assign is_colon = (char_code == CHAR_COLON);
  assign is_dot   = (char_code == CHAR_DOT);

  // block * 10 + digit, wide enough to see overflow
  assign lead_value = (36'(cur.block_value) << 3) + (36'(cur.block_value) << 1)
                      + 36'(digit);
  // fold running seconds; times 60 as (x << 6) - (x << 2)
  assign fold_sum = 33'(cur.seconds_sum) + 33'(cur.block_value);
  assign fold_min = (39'(fold_sum) << 6) - (39'(fold_sum) << 2);
  assign fixed_value = (cur.block_value << 3) + (cur.block_value << 1) + SecWidth'(digit);
  assign frac_next = (cur.fraction_value << 3) + (cur.fraction_value << 1) + MsWidth'(digit);

  always_comb begin
    nxt = cur;
    if (!cur.error_seen) begin
      case (cur.mode)
        MODE_LEAD: begin
          if (is_digit) begin
            if (lead_value[35:32] != 4'd0) begin
              nxt.seconds_sum    = SEC_SAT;
              nxt.block_value    = '0;
              nxt.fraction_value = '0;
              nxt.error_seen     = 1'b1;
            end else begin
              nxt.block_value = lead_value[31:0];
            end
          end else if (is_colon) begin
            if (fold_min[38:32] != 7'd0) begin
              nxt.seconds_sum    = SEC_SAT;
              nxt.block_value    = '0;
              nxt.fraction_value = '0;
              nxt.error_seen     = 1'b1;
            end else begin
              nxt.seconds_sum = fold_min[31:0];
              nxt.block_value = '0;
              nxt.digit_count = 2'd0;
              nxt.mode        = MODE_FIXED;
            end
          end else begin
            nxt.seconds_sum    = '0;
            nxt.block_value    = '0;
            nxt.fraction_value = '0;
            nxt.error_seen     = 1'b1;
          end
        end
        MODE_FIXED: begin
          if (is_digit) begin
            if (cur.digit_count >= 2'd2) begin
              nxt.seconds_sum    = '0;
              nxt.block_value    = '0;
              nxt.fraction_value = '0;
              nxt.error_seen     = 1'b1;
            end else begin
              nxt.block_value = fixed_value;
              nxt.digit_count = cur.digit_count + 2'd1;
            end
          end else if ((is_colon || is_dot) && (cur.digit_count == 2'd2)) begin
            if (is_colon && (fold_min[38:32] != 7'd0)) begin
              nxt.seconds_sum    = SEC_SAT;
              nxt.block_value    = '0;
              nxt.fraction_value = '0;
              nxt.error_seen     = 1'b1;
            end else if (is_dot && fold_sum[32]) begin
              nxt.seconds_sum    = SEC_SAT;
              nxt.block_value    = '0;
              nxt.fraction_value = '0;
              nxt.error_seen     = 1'b1;
            end else begin
              nxt.seconds_sum = is_colon ? fold_min[31:0] : fold_sum[31:0];
              nxt.block_value = '0;
              nxt.digit_count = 2'd0;
              nxt.mode        = is_colon ? MODE_FIXED : MODE_FRAC;
            end
          end else begin
            nxt.seconds_sum    = '0;
            nxt.block_value    = '0;
            nxt.fraction_value = '0;
            nxt.error_seen     = 1'b1;
          end
        end
        MODE_FRAC: begin
          if (is_digit && (cur.digit_count < 2'd3)) begin
            nxt.fraction_value = frac_next;
            nxt.digit_count    = cur.digit_count + 2'd1;
          end else begin
            nxt.seconds_sum    = '0;
            nxt.block_value    = '0;
            nxt.fraction_value = '0;
            nxt.error_seen     = 1'b1;
          end
        end
        default: begin
          nxt.seconds_sum    = '0;
          nxt.block_value    = '0;
          nxt.fraction_value = '0;
          nxt.error_seen     = 1'b1;
        end
      endcase
    end
  end

endmodule

>>> rtl/tsp_emit.sv
// Builds the result word from the state left after the final character.
// Depends on tsp_pkg.
module tsp_emit (
  input  tsp_pkg::parse_state_t st,
  output tsp_pkg::time_word_t   result
);
  import tsp_pkg::*;

  logic [32:0] total_sum;
  logic [13:0] ms_scaled;
  logic        short_block;

  assign total_sum   = 33'(st.seconds_sum) + 33'(st.block_value);
  assign short_block = (st.mode == MODE_FIXED) && (st.digit_count != 2'd2);

  // pad the fraction to milliseconds
  always_comb begin
    case (st.digit_count)
      2'd0:    ms_scaled = '0;
      2'd1:    ms_scaled = 14'(st.fraction_value) * 14'd100;
      2'd2:    ms_scaled = 14'(st.fraction_value) * 14'd10;
      default: ms_scaled = 14'(st.fraction_value);
    endcase
  end

  always_comb begin
    result.total_seconds = st.seconds_sum;
    result.millis        = '0;
    result.parse_ok      = 1'b0;
    if (!st.error_seen) begin
      if (short_block) begin
        result.total_seconds = '0;
      end else if (total_sum[32]) begin
        result.total_seconds = SEC_SAT;
      end else begin
        result.total_seconds = total_sum[31:0];
        result.parse_ok      = 1'b1;
        if (st.mode == MODE_FRAC) begin
          result.millis = ms_scaled[MsWidth-1:0];
        end
      end
    end
  end

endmodule
